>>> hw/rtl/ata_pio_command_sequencer_macros.svh
// ----------------------------------------------------------------------------
// ata pio command sequencer assertion macros
// concurrent assertion shorthands, clocked on clock, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ATA_PIO_COMMAND_SEQUENCER_MACROS_SVH
`define ATA_PIO_COMMAND_SEQUENCER_MACROS_SVH

// same-cycle implication
`define APCS_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("apcs assertion failed");

// next-cycle implication
`define APCS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("apcs assertion failed");

`endif

>>> hw/rtl/apcs_pkg.sv
// ----------------------------------------------------------------------------
// apcs_pkg
// shared types, codes and constants of the ata pio command sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package apcs_pkg;

   localparam int WORDS_PER_SECTOR_DEFAULT = 256;
   localparam int DRIVE_SLOTS_DEFAULT      = 4;

   localparam int QUEUE_PTR_W = 2;

   localparam logic [23:0] POLL_LIMIT_RESET = 24'd500000;
   localparam logic [23:0] POLL_COUNT_MAX   = 24'hFFFFFF;

   // configuration register indexes
   localparam logic CSR_PRESENT_MASK = 1'b0;
   localparam logic CSR_POLL_LIMIT   = 1'b1;

   // task-file offsets
   localparam logic [2:0] REG_DATA      = 3'd0;
   localparam logic [2:0] REG_COUNT     = 3'd2;
   localparam logic [2:0] REG_LBA_LOW   = 3'd3;
   localparam logic [2:0] REG_LBA_MID   = 3'd4;
   localparam logic [2:0] REG_LBA_HIGH  = 3'd5;
   localparam logic [2:0] REG_DEVICE    = 3'd6;
   localparam logic [2:0] REG_CMD_STAT  = 3'd7;

   localparam logic [7:0] ATA_CMD_READ  = 8'h20;
   localparam logic [7:0] ATA_CMD_WRITE = 8'h30;
   localparam logic [7:0] ATA_CMD_FLUSH = 8'hE7;
   localparam logic [7:0] DEVICE_BASE   = 8'hE0;

   localparam int ST_BSY_BIT = 7;
   localparam int ST_DRQ_BIT = 3;
   localparam int ST_ERR_BIT = 0;

   typedef enum logic [2:0] {
      CMD_READ   = 3'd0,
      CMD_WRITE  = 3'd1,
      CMD_FLUSH  = 3'd2,
      CMD_STATUS = 3'd3,
      CMD_DATA   = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      ACT_WRITE_REG   = 3'd0,
      ACT_READ_STATUS = 3'd1,
      ACT_READ_DATA   = 3'd2,
      ACT_WRITE_DATA  = 3'd3,
      ACT_TO_HOST     = 3'd4,
      ACT_DONE_OK     = 3'd5,
      ACT_DONE_FAIL   = 3'd6
   } action_type;

   typedef enum logic [2:0] {
      PH_IDLE       = 3'd0,
      PH_WAIT_READY = 3'd1,
      PH_WAIT_DRQ   = 3'd2,
      PH_READ_DATA  = 3'd3,
      PH_WRITE_DATA = 3'd4,
      PH_WAIT_FINAL = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_FLUSH = 2'd2
   } op_type;

   // leading part of a burst
   typedef enum logic [2:0] {
      HEAD_NONE     = 3'd0,
      HEAD_FLUSH    = 3'd1,
      HEAD_TASKFILE = 3'd2,
      HEAD_TO_HOST  = 3'd3,
      HEAD_WR_WORD  = 3'd4
   } head_type;

   // single closing result of a burst
   typedef enum logic [2:0] {
      TAIL_NONE      = 3'd0,
      TAIL_POLL      = 3'd1,
      TAIL_READ_DATA = 3'd2,
      TAIL_DONE_OK   = 3'd3,
      TAIL_DONE_FAIL = 3'd4
   } tail_type;

   typedef struct packed {
      head_type    head;
      tail_type    tail;
      logic        bus;
      logic        dev;
      logic        is_write;
      logic [27:0] lba;
      logic [7:0]  count;
      logic [15:0] word;
   } burst_type;

   typedef struct packed {
      action_type  action;
      logic        bus;
      logic [2:0]  reg_offset;
      logic [15:0] value;
      logic        last;
   } rsp_type;

endpackage

`default_nettype wire

>>> hw/rtl/apcs_front.sv
// ----------------------------------------------------------------------------
// apcs_front
// accepts items, tracks the protocol phase and queues at most one burst per item
// ----------------------------------------------------------------------------
`default_nettype none

module apcs_front #(
   parameter int WORDS_PER_SECTOR = apcs_pkg::WORDS_PER_SECTOR_DEFAULT,
   parameter int DRIVE_SLOTS      = apcs_pkg::DRIVE_SLOTS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_stall,
   input  wire logic [2:0]         req_command,
   input  wire logic [2:0]         req_drive_index,
   input  wire logic [27:0]        req_lba,
   input  wire logic [7:0]         req_sector_count,
   input  wire logic [7:0]         req_status_value,
   input  wire logic [15:0]        req_data_word,
   input  wire logic               csr_write_enable,
   input  wire logic               csr_index,
   input  wire logic [23:0]        csr_write_data,
   input  wire logic               q_full,
   output      logic               q_push,
   output      apcs_pkg::burst_type q_data
);

   localparam int WC_W = $clog2(WORDS_PER_SECTOR + 1);

   apcs_pkg::phase_type phase_ff, phase_in;
   apcs_pkg::op_type    op_ff, op_in;
   logic [1:0]          drive_ff, drive_in;
   logic [7:0]          sectors_ff, sectors_in;
   logic [WC_W-1:0]     wc_ff, wc_in, wc_next;
   logic [23:0]         poll_ff, poll_in, poll_next, poll_lim;
   logic [27:0]         lba_ff, lba_in;
   logic [7:0]          count_ff, count_in;
   logic [3:0]          present_mask_ff;
   logic [23:0]         poll_limit_ff;
   logic                accept, exhausted, bad_drive;
   logic [7:0]          sec_dec;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         present_mask_ff <= 4'd0;
         poll_limit_ff   <= apcs_pkg::POLL_LIMIT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            apcs_pkg::CSR_PRESENT_MASK: present_mask_ff <= csr_write_data[3:0];
            apcs_pkg::CSR_POLL_LIMIT:   poll_limit_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= apcs_pkg::PH_IDLE;
         op_ff      <= apcs_pkg::OP_READ;
         drive_ff   <= 2'd0;
         sectors_ff <= 8'd0;
         wc_ff      <= '0;
         poll_ff    <= 24'd0;
         lba_ff     <= 28'd0;
         count_ff   <= 8'd0;
      end else begin
         phase_ff   <= phase_in;
         op_ff      <= op_in;
         drive_ff   <= drive_in;
         sectors_ff <= sectors_in;
         wc_ff      <= wc_in;
         poll_ff    <= poll_in;
         lba_ff     <= lba_in;
         count_ff   <= count_in;
      end
   end

   // a poll limit of zero acts as one
   assign poll_lim  = (poll_limit_ff == 24'd0) ? 24'd1 : poll_limit_ff;
   assign poll_next = (poll_ff != apcs_pkg::POLL_COUNT_MAX) ? poll_ff + 24'd1 : poll_ff;
   assign exhausted = poll_next >= poll_lim;
   assign wc_next   = wc_ff + WC_W'(1);
   assign sec_dec   = sectors_ff - 8'd1;
   assign bad_drive = (req_drive_index >= 3'(DRIVE_SLOTS))
                   || !present_mask_ff[req_drive_index[1:0]];

   always_comb begin
      phase_in   = phase_ff;
      op_in      = op_ff;
      drive_in   = drive_ff;
      sectors_in = sectors_ff;
      wc_in      = wc_ff;
      poll_in    = poll_ff;
      lba_in     = lba_ff;
      count_in   = count_ff;
      q_push     = 1'b0;
      q_data.head     = apcs_pkg::HEAD_NONE;
      q_data.tail     = apcs_pkg::TAIL_NONE;
      q_data.bus      = drive_ff[1];
      q_data.dev      = drive_ff[0];
      q_data.is_write = (op_ff == apcs_pkg::OP_WRITE);
      q_data.lba      = lba_ff;
      q_data.count    = count_ff;
      q_data.word     = req_data_word;

      if (accept) begin
         unique case (apcs_pkg::cmd_type'(req_command))
            apcs_pkg::CMD_READ, apcs_pkg::CMD_WRITE, apcs_pkg::CMD_FLUSH: begin
               if (phase_ff == apcs_pkg::PH_IDLE) begin
                  q_push = 1'b1;
                  if (bad_drive) begin
                     q_data.tail = apcs_pkg::TAIL_DONE_FAIL;
                     q_data.bus  = 1'b0;
                  end else begin
                     drive_in   = req_drive_index[1:0];
                     op_in      = apcs_pkg::op_type'(req_command[1:0]);
                     wc_in      = '0;
                     poll_in    = 24'd0;
                     q_data.bus = req_drive_index[1];
                     q_data.dev = req_drive_index[0];
                     q_data.tail = apcs_pkg::TAIL_POLL;
                     if (req_command == apcs_pkg::CMD_FLUSH) begin
                        q_data.head = apcs_pkg::HEAD_FLUSH;
                        phase_in    = apcs_pkg::PH_WAIT_FINAL;
                     end else begin
                        lba_in     = req_lba;
                        count_in   = req_sector_count;
                        sectors_in = req_sector_count;
                        phase_in   = apcs_pkg::PH_WAIT_READY;
                     end
                  end
               end
            end
            apcs_pkg::CMD_STATUS: begin
               unique case (phase_ff)
                  apcs_pkg::PH_WAIT_READY: begin
                     q_push = 1'b1;
                     if (!req_status_value[apcs_pkg::ST_BSY_BIT]) begin
                        q_data.head = apcs_pkg::HEAD_TASKFILE;
                        poll_in     = 24'd0;
                        priority if (sectors_ff != 8'd0) begin
                           q_data.tail = apcs_pkg::TAIL_POLL;
                           phase_in    = apcs_pkg::PH_WAIT_DRQ;
                        end else if (op_ff == apcs_pkg::OP_WRITE) begin
                           q_data.tail = apcs_pkg::TAIL_POLL;
                           phase_in    = apcs_pkg::PH_WAIT_FINAL;
                        end else begin
                           q_data.tail = apcs_pkg::TAIL_DONE_OK;
                           phase_in    = apcs_pkg::PH_IDLE;
                        end
                     end else begin
                        poll_in = poll_next;
                        if (exhausted) begin
                           q_data.tail = apcs_pkg::TAIL_DONE_FAIL;
                           phase_in    = apcs_pkg::PH_IDLE;
                        end else begin
                           q_data.tail = apcs_pkg::TAIL_POLL;
                        end
                     end
                  end
                  apcs_pkg::PH_WAIT_DRQ: begin
                     priority if (req_status_value[apcs_pkg::ST_ERR_BIT]) begin
                        q_push      = 1'b1;
                        q_data.tail = apcs_pkg::TAIL_DONE_FAIL;
                        phase_in    = apcs_pkg::PH_IDLE;
                     end else if (req_status_value[apcs_pkg::ST_DRQ_BIT]) begin
                        wc_in = '0;
                        if (op_ff == apcs_pkg::OP_WRITE) begin
                           phase_in = apcs_pkg::PH_WRITE_DATA;
                        end else begin
                           q_push      = 1'b1;
                           q_data.tail = apcs_pkg::TAIL_READ_DATA;
                           phase_in    = apcs_pkg::PH_READ_DATA;
                        end
                     end else begin
                        q_push  = 1'b1;
                        poll_in = poll_next;
                        if (exhausted) begin
                           q_data.tail = apcs_pkg::TAIL_DONE_FAIL;
                           phase_in    = apcs_pkg::PH_IDLE;
                        end else begin
                           q_data.tail = apcs_pkg::TAIL_POLL;
                        end
                     end
                  end
                  apcs_pkg::PH_WAIT_FINAL: begin
                     q_push = 1'b1;
                     if (!req_status_value[apcs_pkg::ST_BSY_BIT]) begin
                        q_data.tail = apcs_pkg::TAIL_DONE_OK;
                        phase_in    = apcs_pkg::PH_IDLE;
                     end else begin
                        poll_in = poll_next;
                        if (exhausted) begin
                           q_data.tail = apcs_pkg::TAIL_DONE_FAIL;
                           phase_in    = apcs_pkg::PH_IDLE;
                        end else begin
                           q_data.tail = apcs_pkg::TAIL_POLL;
                        end
                     end
                  end
                  default: ;
               endcase
            end
            apcs_pkg::CMD_DATA: begin
               if (phase_ff == apcs_pkg::PH_READ_DATA || phase_ff == apcs_pkg::PH_WRITE_DATA)
               begin
                  q_push      = 1'b1;
                  q_data.head = (phase_ff == apcs_pkg::PH_READ_DATA) ?
                                apcs_pkg::HEAD_TO_HOST : apcs_pkg::HEAD_WR_WORD;
                  if (wc_next == WC_W'(WORDS_PER_SECTOR)) begin
                     // end of sector
                     sectors_in = sec_dec;
                     wc_in      = '0;
                     poll_in    = 24'd0;
                     priority if (sec_dec != 8'd0) begin
                        q_data.tail = apcs_pkg::TAIL_POLL;
                        phase_in    = apcs_pkg::PH_WAIT_DRQ;
                     end else if (op_ff == apcs_pkg::OP_WRITE) begin
                        q_data.tail = apcs_pkg::TAIL_POLL;
                        phase_in    = apcs_pkg::PH_WAIT_FINAL;
                     end else begin
                        q_data.tail = apcs_pkg::TAIL_DONE_OK;
                        phase_in    = apcs_pkg::PH_IDLE;
                     end
                  end else begin
                     wc_in       = wc_next;
                     q_data.tail = (phase_ff == apcs_pkg::PH_READ_DATA) ?
                                   apcs_pkg::TAIL_READ_DATA : apcs_pkg::TAIL_NONE;
                  end
               end
            end
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/apcs_queue.sv
// ----------------------------------------------------------------------------
// apcs_queue
// short burst queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module apcs_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire apcs_pkg::burst_type push_data,
   input  wire logic                pop,
   output      apcs_pkg::burst_type pop_data,
   output      logic                full,
   output      logic                empty
);

   localparam int PW    = apcs_pkg::QUEUE_PTR_W;
   localparam int DEPTH = 1 << PW;

   apcs_pkg::burst_type slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PW:0]   count_ff;
   logic          do_push, do_pop;

   assign full     = (count_ff == (PW+1)'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + PW'(1);
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + PW'(1);
         unique case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + (PW+1)'(1);
            2'b01:   count_ff <= count_ff - (PW+1)'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/apcs_back.sv
// ----------------------------------------------------------------------------
// apcs_back
// expands each queued burst into bus accesses, one result per cycle while the output is not stalled
// ----------------------------------------------------------------------------
`default_nettype none

module apcs_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_empty,
   input  wire apcs_pkg::burst_type q_data,
   output      logic                q_pop,
   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      apcs_pkg::rsp_type   rsp
);

   apcs_pkg::burst_type burst_ff;
   logic [2:0]          step_ff, step_in;
   logic                busy_ff, busy_in;
   logic                rsp_valid_ff, rsp_valid_in;
   apcs_pkg::rsp_type   rsp_ff, result;
   logic [2:0]          head_len, total;
   logic                out_free, emit, last_step;

   always_comb begin
      unique case (burst_ff.head)
         apcs_pkg::HEAD_FLUSH:    head_len = 3'd2;
         apcs_pkg::HEAD_TASKFILE: head_len = 3'd6;
         apcs_pkg::HEAD_TO_HOST,
         apcs_pkg::HEAD_WR_WORD:  head_len = 3'd1;
         default:                 head_len = 3'd0;
      endcase
   end

   assign total     = head_len + {2'b00, burst_ff.tail != apcs_pkg::TAIL_NONE};
   assign last_step = (step_ff == total - 3'd1);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit      = busy_ff && out_free;
   assign q_pop     = !busy_ff && !q_empty;

   // result at the current step
   always_comb begin
      result.action     = apcs_pkg::ACT_WRITE_REG;
      result.bus        = burst_ff.bus;
      result.reg_offset = apcs_pkg::REG_DATA;
      result.value      = 16'd0;
      result.last       = 1'b0;
      if (step_ff < head_len) begin
         unique case (burst_ff.head)
            apcs_pkg::HEAD_FLUSH: begin
               if (step_ff == 3'd0) begin
                  result.reg_offset = apcs_pkg::REG_DEVICE;
                  result.value = {8'h00, apcs_pkg::DEVICE_BASE | {3'b000, burst_ff.dev, 4'h0}};
               end else begin
                  result.reg_offset = apcs_pkg::REG_CMD_STAT;
                  result.value      = {8'h00, apcs_pkg::ATA_CMD_FLUSH};
               end
            end
            apcs_pkg::HEAD_TASKFILE: begin
               case (step_ff)
                  3'd0: begin
                     result.reg_offset = apcs_pkg::REG_DEVICE;
                     result.value = {8'h00, apcs_pkg::DEVICE_BASE
                                     | {3'b000, burst_ff.dev, burst_ff.lba[27:24]}};
                  end
                  3'd1: begin
                     result.reg_offset = apcs_pkg::REG_COUNT;
                     result.value      = {8'h00, burst_ff.count};
                  end
                  3'd2: begin
                     result.reg_offset = apcs_pkg::REG_LBA_LOW;
                     result.value      = {8'h00, burst_ff.lba[7:0]};
                  end
                  3'd3: begin
                     result.reg_offset = apcs_pkg::REG_LBA_MID;
                     result.value      = {8'h00, burst_ff.lba[15:8]};
                  end
                  3'd4: begin
                     result.reg_offset = apcs_pkg::REG_LBA_HIGH;
                     result.value      = {8'h00, burst_ff.lba[23:16]};
                  end
                  default: begin
                     result.reg_offset = apcs_pkg::REG_CMD_STAT;
                     result.value = {8'h00, burst_ff.is_write ?
                                     apcs_pkg::ATA_CMD_WRITE : apcs_pkg::ATA_CMD_READ};
                  end
               endcase
            end
            apcs_pkg::HEAD_TO_HOST: begin
               result.action = apcs_pkg::ACT_TO_HOST;
               result.value  = burst_ff.word;
            end
            apcs_pkg::HEAD_WR_WORD: begin
               result.action = apcs_pkg::ACT_WRITE_DATA;
               result.value  = burst_ff.word;
            end
            default: ;
         endcase
      end else begin
         unique case (burst_ff.tail)
            apcs_pkg::TAIL_POLL: begin
               result.action     = apcs_pkg::ACT_READ_STATUS;
               result.reg_offset = apcs_pkg::REG_CMD_STAT;
            end
            apcs_pkg::TAIL_READ_DATA: result.action = apcs_pkg::ACT_READ_DATA;
            apcs_pkg::TAIL_DONE_OK: begin
               result.action = apcs_pkg::ACT_DONE_OK;
               result.last   = 1'b1;
            end
            apcs_pkg::TAIL_DONE_FAIL: begin
               result.action = apcs_pkg::ACT_DONE_FAIL;
               result.last   = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (emit) begin
         step_in = step_ff + 3'd1;
         if (last_step) busy_in = 1'b0;
      end else if (q_pop) begin
         busy_in = 1'b1;
         step_in = 3'd0;
      end
      if (emit) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) burst_ff <= q_data;
      if (emit)  rsp_ff   <= result;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

>>> hw/rtl/ata_pio_command_sequencer.sv
// ----------------------------------------------------------------------------
// ata_pio_command_sequencer
// host-side ata pio task-file sequencer for lba28 read, write and cache flush
// ----------------------------------------------------------------------------
// the front accepts one item per cycle as long as the four-entry burst queue
// has room, and updates the protocol phase at once; each item that causes
// results queues one burst. the back turns a burst into bus accesses through
// a registered output at one result per cycle while the output is not stalled;
// it loads a burst only when idle, after the last result of the one before
// (a taskfile burst has seven results). items that cause no result cost the
// back nothing. configuration writes land at once.
`default_nettype none

module ata_pio_command_sequencer #(
   parameter int WORDS_PER_SECTOR = apcs_pkg::WORDS_PER_SECTOR_DEFAULT,
   parameter int DRIVE_SLOTS      = apcs_pkg::DRIVE_SLOTS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [2:0]  req_command,
   input  wire logic [2:0]  req_drive_index,
   input  wire logic [27:0] req_lba,
   input  wire logic [7:0]  req_sector_count,
   input  wire logic [7:0]  req_status_value,
   input  wire logic [15:0] req_data_word,
   // result channel
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [2:0]  rsp_action,
   output      logic        rsp_bus,
   output      logic [2:0]  rsp_reg_offset,
   output      logic [15:0] rsp_value,
   output      logic        rsp_last,
   // configuration
   input  wire logic        csr_write_enable,
   input  wire logic        csr_index,
   input  wire logic [23:0] csr_write_data
);

   apcs_pkg::burst_type push_data, pop_data;
   apcs_pkg::rsp_type   rsp;
   logic                q_push, q_pop, q_full, q_empty;

   // front: classify item, advance phase
   apcs_front #(
      .WORDS_PER_SECTOR (WORDS_PER_SECTOR),
      .DRIVE_SLOTS      (DRIVE_SLOTS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_drive_index  (req_drive_index),
      .req_lba          (req_lba),
      .req_sector_count (req_sector_count),
      .req_status_value (req_status_value),
      .req_data_word    (req_data_word),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_data           (push_data)
   );

   // burst queue decouples the two sides
   apcs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   // back: burst expansion and output register
   apcs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (pop_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   assign rsp_action     = rsp.action;
   assign rsp_bus        = rsp.bus;
   assign rsp_reg_offset = rsp.reg_offset;
   assign rsp_value      = rsp.value;
   assign rsp_last       = rsp.last;

endmodule

`default_nettype wire

>>> hw/rtl/apcs_checker.sv
// ----------------------------------------------------------------------------
// apcs_checker
// port-level checks on the result channel of the sequencer
// ----------------------------------------------------------------------------
`default_nettype none

`include "ata_pio_command_sequencer_macros.svh"

module apcs_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [2:0]  rsp_action,
   input wire logic [2:0]  rsp_reg_offset,
   input wire logic [15:0] rsp_value,
   input wire logic        rsp_last
);

   // a stalled item stays offered
   `APCS_ASSERT_NEXT(a_valid_holds, rsp_valid && rsp_stall, rsp_valid)

   // last marks exactly the completions
   `APCS_ASSERT_IMPLY(a_last_on_done, rsp_valid, rsp_last == ((rsp_action == apcs_pkg::ACT_DONE_OK) || (rsp_action == apcs_pkg::ACT_DONE_FAIL)))

   // status polls address the status register with no data
   `APCS_ASSERT_IMPLY(a_poll_form, rsp_valid && (rsp_action == apcs_pkg::ACT_READ_STATUS), (rsp_reg_offset == apcs_pkg::REG_CMD_STAT) && (rsp_value == 16'd0))

   // register writes carry a byte only
   `APCS_ASSERT_IMPLY(a_reg_byte, rsp_valid && (rsp_action == apcs_pkg::ACT_WRITE_REG), rsp_value[15:8] == 8'h00)

endmodule

bind ata_pio_command_sequencer apcs_checker u_checker (.*);

`default_nettype wire
